/* rtl/als_pkg.sv */
// Shared types and constants for the anti-aliased line stepper.
// Holds the fixed-point widths, the input kind codes and the command word
// passed from the front end to the back end. No dependencies.
package als_pkg;

	localparam int COORD_BITS  = 12;
	localparam int FRAC_BITS   = 16;
	localparam int HUE_BITS    = 9;
	localparam int INT_BITS    = COORD_BITS + FRAC_BITS + 1;
	localparam int GRAD_BITS   = FRAC_BITS + 2;
	localparam int LEVEL_BITS  = FRAC_BITS + 1;
	localparam int MAG_BITS    = COORD_BITS + 1;
	localparam int DIV_CNT_BITS = $clog2(FRAC_BITS);
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_STEP = 1'b1;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [GRAD_BITS-1:0]  grad_t;
	typedef logic signed [INT_BITS-1:0]   isect_t;
	typedef logic [MAG_BITS-1:0]          mag_t;
	typedef logic [HUE_BITS-1:0]          hue_t;

	// One queued command: a segment set-up or a column step
	typedef struct packed {
		logic   is_load;
		logic   steep;
		coord_t major_start;
		coord_t major_end;
		coord_t minor_start;
		grad_t  gradient;
		hue_t   hue;
	} cmd_t;

endpackage

/* rtl/antialiased_line_stepper_top.sv */
// Anti-aliased line stepper, top level: front end, command queue, back end.
// Step beats sustain one per cycle unless the queue or the result channel stalls;
// each step passes the pending register, a queue slot and the output register.
// A load whose slope is not exactly one waits on the one-bit-a-cycle divider.
// Reset (arst_n low, asynchronous) empties the queue and leaves the segment idle.
// Depends on als_pkg, als_front, als_queue and als_back.
module antialiased_line_stepper_top (
	input  logic            clk,
	input  logic            arst_n,
	// input channel
	input  logic            in_valid,
	output logic            in_stall,
	input  logic            kind,
	input  als_pkg::coord_t x_start,
	input  als_pkg::coord_t y_start,
	input  als_pkg::coord_t x_end,
	input  als_pkg::coord_t y_end,
	input  als_pkg::hue_t   hue,
	// result channel
	output logic            out_valid,
	input  logic            out_stall,
	output als_pkg::coord_t near_x,
	output als_pkg::coord_t near_y,
	output als_pkg::coord_t far_x,
	output als_pkg::coord_t far_y,
	output logic [als_pkg::LEVEL_BITS-1:0] near_level,
	output logic [als_pkg::FRAC_BITS-1:0]  far_level,
	output als_pkg::hue_t   pixel_hue,
	output logic            last
);
	import als_pkg::*;

	// Front to queue: one command beat at a time, held while the queue is full
	logic push_valid, push_full;
	cmd_t push_cmd;

	// Queue to back end: the back end pops a step only when its output
	// register is free, but drops a step that arrives while idle
	logic head_valid, pop;
	cmd_t head_cmd;

	// Classify beats, order the endpoints and divide out the gradient.
	// Hold further input while a division is running.
	als_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.x_start    (x_start),
		.y_start    (y_start),
		.x_end      (x_end),
		.y_end      (y_end),
		.hue        (hue),
		.push_valid (push_valid),
		.push_cmd   (push_cmd),
		.push_full  (push_full)
	);

	// Decouple the two halves so a stalled result does not block set-up
	als_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_cmd   (push_cmd),
		.push_full  (push_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	// Advance the intersection by the gradient each column and register
	// the near and far pixels, unswapping coordinates for steep lines
	als_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.near_x     (near_x),
		.near_y     (near_y),
		.far_x      (far_x),
		.far_y      (far_y),
		.near_level (near_level),
		.far_level  (far_level),
		.pixel_hue  (pixel_hue),
		.last       (last)
	);

endmodule

/* rtl/als_front.sv */
// Front end: accepts beats, orders segment endpoints and forms the gradient.
// The gradient comes from a restoring divider, one quotient bit a cycle.
// Depends on als_pkg.
module als_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  kind,
	input  als_pkg::coord_t       x_start,
	input  als_pkg::coord_t       y_start,
	input  als_pkg::coord_t       x_end,
	input  als_pkg::coord_t       y_end,
	input  als_pkg::hue_t         hue,
	output logic                  push_valid,
	output als_pkg::cmd_t         push_cmd,
	input  logic                  push_full
);
	import als_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_DIV  = 3'b010,
		S_DONE = 3'b100
	} front_state_t;

	localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(FRAC_BITS - 1);

	front_state_t              state_q;
	logic                      pend_valid_q;
	cmd_t                      pend_q;
	cmd_t                      hold_q;
	logic                      neg_q;
	mag_t                      rem_q;
	mag_t                      den_q;
	logic [FRAC_BITS-1:0]      quo_q;
	logic [DIV_CNT_BITS-1:0]   cnt_q;

	logic signed [MAG_BITS-1:0] dxs, dys, dy_ord;
	mag_t                       adx, ady, maj_mag, min_mag;
	logic                       steep, swap_ends, unit_slope, accept, pend_free;
	coord_t                     a_maj, a_min, b_maj, b_min, lo_maj, lo_min, hi_maj, hi_min;
	cmd_t                       in_cmd;
	grad_t                      unit_grad, div_grad;
	logic [MAG_BITS:0]          trial;
	logic                       qbit;
	mag_t                       rem_next;

	always_comb begin
		dxs = {x_end[COORD_BITS-1], x_end} - {x_start[COORD_BITS-1], x_start};
		dys = {y_end[COORD_BITS-1], y_end} - {y_start[COORD_BITS-1], y_start};
		adx = dxs[MAG_BITS-1] ? mag_t'(-dxs) : mag_t'(dxs);
		ady = dys[MAG_BITS-1] ? mag_t'(-dys) : mag_t'(dys);
		steep = ady > adx;
		a_maj = steep ? y_start : x_start;
		a_min = steep ? x_start : y_start;
		b_maj = steep ? y_end : x_end;
		b_min = steep ? x_end : y_end;
		swap_ends = a_maj > b_maj;
		lo_maj = swap_ends ? b_maj : a_maj;
		lo_min = swap_ends ? b_min : a_min;
		hi_maj = swap_ends ? a_maj : b_maj;
		hi_min = swap_ends ? a_min : b_min;
		dy_ord = {hi_min[COORD_BITS-1], hi_min} - {lo_min[COORD_BITS-1], lo_min};
		maj_mag = steep ? ady : adx;
		min_mag = steep ? adx : ady;
		// equal run and rise (zero length too) gives exactly one
		unit_slope = (maj_mag == min_mag);
		unit_grad = dy_ord[MAG_BITS-1] ? -(grad_t'(1) <<< FRAC_BITS)
			: (grad_t'(1) <<< FRAC_BITS);

		in_cmd.is_load     = (kind == KIND_LOAD);
		in_cmd.steep       = steep;
		in_cmd.major_start = lo_maj;
		in_cmd.major_end   = hi_maj;
		in_cmd.minor_start = lo_min;
		in_cmd.gradient    = unit_grad;
		in_cmd.hue         = hue;
	end

	// One restoring step; the remainder stays below the divisor
	always_comb begin
		trial = {rem_q, 1'b0};
		qbit  = trial >= {1'b0, den_q};
		rem_next = qbit ? mag_t'(trial - {1'b0, den_q}) : mag_t'(trial);
		div_grad = neg_q ? -grad_t'({2'b00, quo_q}) : grad_t'({2'b00, quo_q});
	end

	assign pend_free  = !pend_valid_q || !push_full;
	assign in_stall   = (state_q != S_IDLE) || !pend_free;
	assign accept     = in_valid && !in_stall;
	assign push_valid = pend_valid_q;
	assign push_cmd   = pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			pend_valid_q <= 1'b0;
			cnt_q        <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept && kind == KIND_LOAD && !unit_slope) begin
						state_q <= S_DIV;
						cnt_q   <= '0;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIV_LAST) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (pend_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (accept && (kind == KIND_STEP || unit_slope)) begin
				pend_valid_q <= 1'b1;
			end else if (state_q == S_DONE && pend_free) begin
				pend_valid_q <= 1'b1;
			end else if (!push_full) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (kind == KIND_STEP || unit_slope)) begin
			pend_q <= in_cmd;
		end else if (state_q == S_DONE && pend_free) begin
			pend_q          <= hold_q;
			pend_q.gradient <= div_grad;
		end
		if (accept) begin
			hold_q <= in_cmd;
			neg_q  <= dy_ord[MAG_BITS-1];
			rem_q  <= min_mag;
			den_q  <= maj_mag;
			quo_q  <= '0;
		end else if (state_q == S_DIV) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[FRAC_BITS-2:0], qbit};
		end
	end

endmodule

/* rtl/als_queue.sv */
// Command queue between front and back end, held in flip-flops.
// Depends on als_pkg.
module als_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	input  als_pkg::cmd_t  push_cmd,
	output logic           push_full,
	input  logic           pop,
	output logic           head_valid,
	output als_pkg::cmd_t  head_cmd
);
	import als_pkg::*;

	localparam logic [QPTR_BITS:0] FULL_COUNT = (QPTR_BITS+1)'(QUEUE_DEPTH);

	cmd_t                 slot_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_BITS:0]   count_q;
	logic                 push, pull;

	assign push_full  = (count_q == FULL_COUNT);
	assign head_valid = (count_q != '0);
	assign head_cmd   = slot_q[rd_ptr_q];
	assign push       = push_valid && !push_full;
	assign pull       = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pull) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pull) begin
				count_q <= count_q + 1'b1;
			end else if (pull && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

/* rtl/als_back.sv */
// Back end: holds the segment state, steps one column per step command and
// registers the pixel pair. Depends on als_pkg.
module als_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  als_pkg::cmd_t   head_cmd,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_stall,
	output als_pkg::coord_t near_x,
	output als_pkg::coord_t near_y,
	output als_pkg::coord_t far_x,
	output als_pkg::coord_t far_y,
	output logic [als_pkg::LEVEL_BITS-1:0] near_level,
	output logic [als_pkg::FRAC_BITS-1:0]  far_level,
	output als_pkg::hue_t   pixel_hue,
	output logic            last
);
	import als_pkg::*;

	logic   active_q, steep_q, out_valid_q;
	coord_t pos_q, end_q;
	isect_t isect_q;
	grad_t  grad_q;
	hue_t   hue_q;

	coord_t                nx_q, ny_q, fx_q, fy_q;
	logic [LEVEL_BITS-1:0] nlev_q;
	logic [FRAC_BITS-1:0]  flev_q;
	hue_t                  phue_q;
	logic                  last_q;

	logic                  out_free, emit, fin;
	coord_t                fl, fl_dn;
	logic [FRAC_BITS-1:0]  fr;

	assign out_free = !out_valid_q || !out_stall;
	assign pop  = head_valid && (head_cmd.is_load || !active_q || out_free);
	assign emit = pop && !head_cmd.is_load && active_q;

	always_comb begin
		fl    = isect_q[INT_BITS-2:FRAC_BITS];
		fl_dn = fl - 1'b1;
		fr    = isect_q[FRAC_BITS-1:0];
		fin   = (pos_q == end_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && head_cmd.is_load) begin
				active_q <= 1'b1;
			end else if (emit && fin) begin
				active_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head_cmd.is_load) begin
			steep_q <= head_cmd.steep;
			pos_q   <= head_cmd.major_start;
			end_q   <= head_cmd.major_end;
			isect_q <= {head_cmd.minor_start[COORD_BITS-1], head_cmd.minor_start,
				{FRAC_BITS{1'b0}}};
			grad_q  <= head_cmd.gradient;
			hue_q   <= head_cmd.hue;
		end else if (emit && !fin) begin
			pos_q   <= pos_q + 1'b1;
			isect_q <= isect_q + {{(INT_BITS-GRAD_BITS){grad_q[GRAD_BITS-1]}}, grad_q};
		end
		if (emit) begin
			nx_q   <= steep_q ? fl : pos_q;
			ny_q   <= steep_q ? pos_q : fl;
			fx_q   <= steep_q ? fl_dn : pos_q;
			fy_q   <= steep_q ? pos_q : fl_dn;
			nlev_q <= (LEVEL_BITS'(1) << FRAC_BITS) - {1'b0, fr};
			flev_q <= fr;
			phue_q <= hue_q;
			last_q <= fin;
		end
	end

	assign out_valid  = out_valid_q;
	assign near_x     = nx_q;
	assign near_y     = ny_q;
	assign far_x      = fx_q;
	assign far_y      = fy_q;
	assign near_level = nlev_q;
	assign far_level  = flev_q;
	assign pixel_hue  = phue_q;
	assign last       = last_q;

endmodule
